// ===== hw/rtl/aceu_pkg.sv =====
// Shared types and opcode codes for the accumulator CPU execute unit.
package aceu_pkg;

  localparam int unsigned AddrW = 16;
  localparam int unsigned DataW = 8;

  typedef enum logic [7:0] {
    OP_END  = 8'd0,
    OP_LOAD = 8'd1,
    OP_STORE = 8'd2,
    OP_SWAP = 8'd3,
    OP_SHL  = 8'd7,
    OP_SHR  = 8'd8,
    OP_JUMP = 8'd11,
    OP_TEST = 8'd12,
    OP_AND  = 8'd14,
    OP_OR   = 8'd15,
    OP_ADD  = 8'd19,
    OP_SUB  = 8'd20
  } opcode_e;

  typedef struct packed {
    logic [7:0]       opcode;
    logic [DataW-1:0] operand_first;
    logic [DataW-1:0] operand_second;
    logic [DataW-1:0] operand_third;
    logic [DataW-1:0] mem_data;
  } instr_t;

  typedef struct packed {
    logic [AddrW-1:0] pc;
    logic [DataW-1:0] acc;
    logic [DataW-1:0] aux;
  } arch_t;

  typedef struct packed {
    logic [AddrW-1:0] next_pc;
    logic [DataW-1:0] acc_out;
    logic [DataW-1:0] aux_out;
    logic             write_enable;
    logic [AddrW-1:0] write_addr;
    logic [DataW-1:0] write_data;
    logic             halted;
    logic             illegal;
  } result_t;

endpackage

// ===== hw/rtl/aceu_in_reg.sv =====
// Input register stage: holds one instruction transaction until execute takes it.
module aceu_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  aceu_pkg::instr_t instr_i,
  input  logic            take_i,
  output logic            valid_o,
  output aceu_pkg::instr_t instr_o
);
  import aceu_pkg::*;

  logic   valid_q, valid_d;
  instr_t instr_q;
  logic   accept;

  // Stall only while a held instruction is not being taken this cycle.
  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      instr_q <= instr_i;
    end
  end

  assign valid_o = valid_q;
  assign instr_o = instr_q;

endmodule

// ===== hw/rtl/aceu_exec.sv =====
// Execute logic: next PC, A, C and store request for one instruction.
module aceu_exec (
  input  aceu_pkg::instr_t  instr_i,
  input  aceu_pkg::arch_t   arch_i,
  input  logic [15:0]       reset_vector_i,
  output aceu_pkg::result_t res_o
);
  import aceu_pkg::*;

  logic [AddrW-1:0] pc_inc1;
  logic [AddrW-1:0] pc_inc3;
  logic [AddrW-1:0] addr;
  logic [AddrW-1:0] pair;
  logic [DataW-1:0] offset;
  logic [DataW-1:0] and_val;
  logic [DataW-1:0] or_val;
  logic [AddrW-1:0] sum;
  logic [AddrW-1:0] diff;

  assign pc_inc1 = arch_i.pc + 16'd1;
  assign pc_inc3 = arch_i.pc + 16'd3;
  assign addr    = {instr_i.operand_second, instr_i.operand_first};
  assign pair    = {arch_i.aux, arch_i.acc};
  assign and_val = arch_i.acc & instr_i.mem_data;
  assign or_val  = arch_i.acc | instr_i.mem_data;
  assign sum     = {8'h00, arch_i.acc} + {8'h00, instr_i.mem_data};
  assign diff    = {8'h00, arch_i.acc} - {8'h00, instr_i.mem_data};

  // Three-way branch on the sign of A: negative, zero, positive.
  always_comb begin
    if (arch_i.acc[DataW-1]) begin
      offset = instr_i.operand_first;
    end else if (arch_i.acc == '0) begin
      offset = instr_i.operand_second;
    end else begin
      offset = instr_i.operand_third;
    end
  end

  always_comb begin
    res_o              = '0;
    res_o.next_pc      = pc_inc3;
    res_o.acc_out      = arch_i.acc;
    res_o.aux_out      = arch_i.aux;
    case (instr_i.opcode)
      OP_END: begin
        res_o.halted  = 1'b1;
        res_o.next_pc = pc_inc1;
      end
      OP_LOAD: begin
        res_o.acc_out = instr_i.mem_data;
      end
      OP_STORE: begin
        res_o.write_enable = 1'b1;
        res_o.write_addr   = addr;
        res_o.write_data   = arch_i.acc;
      end
      OP_SWAP: begin
        res_o.acc_out = arch_i.aux;
        res_o.aux_out = arch_i.acc;
        res_o.next_pc = pc_inc1;
      end
      OP_SHL: begin
        {res_o.aux_out, res_o.acc_out} = {pair[AddrW-2:0], 1'b0};
        res_o.next_pc = pc_inc1;
      end
      OP_SHR: begin
        {res_o.aux_out, res_o.acc_out} = {1'b0, pair[AddrW-1:1]};
        res_o.next_pc = pc_inc1;
      end
      OP_JUMP: begin
        {res_o.aux_out, res_o.acc_out} = pc_inc3;
        res_o.next_pc = addr;
      end
      OP_TEST: begin
        res_o.next_pc = pc_inc1 + {{8{offset[DataW-1]}}, offset};
      end
      OP_AND: begin
        res_o.acc_out = and_val;
        res_o.aux_out = ~and_val;
      end
      OP_OR: begin
        res_o.acc_out = or_val;
        res_o.aux_out = ~or_val;
      end
      OP_ADD: begin
        {res_o.aux_out, res_o.acc_out} = sum;
      end
      OP_SUB: begin
        {res_o.aux_out, res_o.acc_out} = diff;
      end
      default: begin
        // Unknown opcode: restart from the reset vector with cleared registers.
        res_o.illegal = 1'b1;
        res_o.next_pc = reset_vector_i;
        res_o.acc_out = '0;
        res_o.aux_out = '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/accumulator_cpu_execute_unit.sv =====
// Top level of the accumulator CPU execute unit: state, output register, config.
//
//  channel | direction | handshake                | payload
//  in      | input     | in_valid_i / in_stall_o  | opcode, three operands, mem_data
//  out     | output    | out_valid_o / out_stall_i| next_pc, A, C, store, halted, illegal
//  cfg     | input     | cfg_valid_i / cfg_ready_o| reset vector (16 bit)
//
// One instruction per cycle sustained while the output is not stalled; an input transaction
// reaches the result through the input register and then the result register around the execute logic.
// PC, A and C update in the cycle an instruction leaves the input register, so the next
// one sees them directly. Reset clears A and C and sets PC and the reset vector to zero.
// A stalled output holds its result; the input register takes one more instruction.
module accumulator_cpu_execute_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  opcode_i,
  input  logic [7:0]  operand_first_i,
  input  logic [7:0]  operand_second_i,
  input  logic [7:0]  operand_third_i,
  input  logic [7:0]  mem_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] next_pc_o,
  output logic [7:0]  acc_out_o,
  output logic [7:0]  aux_out_o,
  output logic        write_enable_o,
  output logic [15:0] write_addr_o,
  output logic [7:0]  write_data_o,
  output logic        halted_o,
  output logic        illegal_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import aceu_pkg::*;

  instr_t  in_instr;
  instr_t  ex_instr;
  logic    ex_valid;
  logic    take;
  logic    out_adv;
  result_t ex_res;

  arch_t            arch_q, arch_d;
  logic [AddrW-1:0] rv_q;
  logic             out_valid_q, out_valid_d;
  result_t          out_q;

  assign in_instr = '{opcode:         opcode_i,
                      operand_first:  operand_first_i,
                      operand_second: operand_second_i,
                      operand_third:  operand_third_i,
                      mem_data:       mem_data_i};

  aceu_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .instr_i    (in_instr),
    .take_i     (take),
    .valid_o    (ex_valid),
    .instr_o    (ex_instr)
  );

  aceu_exec u_exec (
    .instr_i        (ex_instr),
    .arch_i         (arch_q),
    .reset_vector_i (rv_q),
    .res_o          (ex_res)
  );

  assign out_adv = !out_valid_q || !out_stall_i;
  assign take    = ex_valid && out_adv;

  always_comb begin
    arch_d      = arch_q;
    out_valid_d = out_valid_q;
    if (take) begin
      arch_d      = '{pc: ex_res.next_pc, acc: ex_res.acc_out, aux: ex_res.aux_out};
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arch_q      <= '0;
      rv_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      arch_q      <= arch_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        rv_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= ex_res;
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign next_pc_o      = out_q.next_pc;
  assign acc_out_o      = out_q.acc_out;
  assign aux_out_o      = out_q.aux_out;
  assign write_enable_o = out_q.write_enable;
  assign write_addr_o   = out_q.write_addr;
  assign write_data_o   = out_q.write_data;
  assign halted_o       = out_q.halted;
  assign illegal_o      = out_q.illegal;

endmodule

// ===== hw/rtl/aceu_checker.sv =====
// Port-level checks for the accumulator CPU execute unit, bound to the top level.
module aceu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] next_pc_o,
  input logic [7:0]  acc_out_o,
  input logic [7:0]  aux_out_o,
  input logic        write_enable_o,
  input logic [15:0] write_addr_o,
  input logic [7:0]  write_data_o,
  input logic        halted_o,
  input logic        illegal_o
);

  // No result transaction is offered while in reset.
  a_no_out_in_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(next_pc_o) && $stable(acc_out_o))
    else $error("stalled result changed");

  // Illegal opcode clears A and C and carries no store or halt.
  a_illegal_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && illegal_o |-> acc_out_o == 8'h00 && aux_out_o == 8'h00
                                 && !write_enable_o && !halted_o)
    else $error("illegal result not cleared");

  // Store fields are zero unless a store is requested.
  a_store_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_enable_o |-> write_addr_o == 16'h0000 && write_data_o == 8'h00)
    else $error("store fields set without store");

  // A store reports A unchanged in its write data.
  a_store_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_enable_o |-> write_data_o == acc_out_o && !halted_o)
    else $error("store data differs from A");

endmodule

bind accumulator_cpu_execute_unit aceu_checker u_aceu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .next_pc_o      (next_pc_o),
  .acc_out_o      (acc_out_o),
  .aux_out_o      (aux_out_o),
  .write_enable_o (write_enable_o),
  .write_addr_o   (write_addr_o),
  .write_data_o   (write_data_o),
  .halted_o       (halted_o),
  .illegal_o      (illegal_o)
);
